// ===== hw/rtl/tpsrx_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsrx_pkg
// Shared types and constants of the TPS differential BPSK receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package tpsrx_pkg;

  // sizing of the carrier store and the TPS frame
  localparam int MAX_CARRIERS   = 68;
  localparam int FRAME_BITS     = 68;
  localparam int SYNC_END_INDEX = 17;

  localparam int CPOS_W  = $clog2(MAX_CARRIERS + 1);
  localparam int CADDR_W = (MAX_CARRIERS > 1) ? $clog2(MAX_CARRIERS) : 1;
  localparam int BPOS_MAX = (FRAME_BITS > SYNC_END_INDEX) ? FRAME_BITS : SYNC_END_INDEX;
  localparam int BPOS_W  = $clog2(BPOS_MAX + 1);
  localparam int FIDX_W  = $clog2(FRAME_BITS);

  localparam int SMP_W   = 16;
  localparam int VOTE_W  = 7;
  localparam int SYNC_W  = 16;
  localparam int SYM_W   = 7;

  localparam logic [VOTE_W-1:0] VOTE_MAX = {VOTE_W{1'b1}};
  localparam logic [SYNC_W-1:0] SYNC_WORD_RST = 16'd13806;

  // frame bit positions of the signalling fields, first bit is msb
  localparam int FLD_FRAME_NUM = 23;
  localparam int FLD_CONST     = 25;
  localparam int FLD_HIER      = 27;
  localparam int FLD_CR_HP     = 30;
  localparam int FLD_CR_LP     = 33;
  localparam int FLD_GUARD     = 36;
  localparam int FLD_MODE      = 38;

  // register file
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_SYNC_WORD = 1'b0;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_re;
    logic signed [SMP_W-1:0] sample_im;
    logic                    last_carrier;
  } tps_in_t;

  typedef struct packed {
    logic             tps_bit_value;
    logic [SYM_W-1:0] symbol_index;
    logic [1:0]       frame_number;
    logic             uncertain;
    logic             resynced;
    logic             frame_done;
    logic [1:0]       constellation;
    logic [2:0]       hierarchy;
    logic [2:0]       code_rate_hp;
    logic [2:0]       code_rate_lp;
    logic [1:0]       guard_interval;
    logic [1:0]       fft_mode;
  } tps_out_t;

  // vote totals of one finished symbol
  typedef struct packed {
    logic [VOTE_W-1:0] zero_votes;
    logic [VOTE_W-1:0] one_votes;
  } vote_tally_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ofdm_tps_dbpsk_receiver.sv =====
// ----------------------------------------------------------------------------
// ofdm_tps_dbpsk_receiver
// DVB-T TPS receiver: differential BPSK bit decision, sync search and frame
// field decoding.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one TPS pilot sample per transaction (I/Q, last_carrier flag).
//           A transaction completes on a clock edge with in_valid high and
//           in_stall low. One sample can be taken every cycle.
//   out_* : one transaction per symbol, raised by the sample flagged
//           last_carrier; other samples give no result.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready : register port,
//           sync_word at byte address 0, pready always high.
// Path: the result of a last-carrier sample passes the stage 1, stage 2 and tally
//   registers of tpsrx_vote and then the output register on its way to out_data.
// Throughput: 1 sample per cycle while in_stall is low, set by the single read-modify-write
//   of the carrier store per sample (read-first port, old out and new in the same cycle).
// Reset (rst_n low, synchronous): carrier store entries are marked unwritten
//   at once and read as zero; counters, sync shifter and frame are cleared,
//   sync_word returns to 13806. No sweep, samples are taken right after reset.
// Stall: out_stall holds the result; the pipeline keeps filling its empty
//   stages and raises in_stall only once every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module ofdm_tps_dbpsk_receiver (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  tpsrx_pkg::tps_in_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output tpsrx_pkg::tps_out_t                  out_data,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [tpsrx_pkg::CFG_AW-1:0]          paddr,
  input  wire [tpsrx_pkg::CFG_DW-1:0]          pwdata,
  output logic [tpsrx_pkg::CFG_DW-1:0]         prdata,
  output logic                                 pready
);
  import tpsrx_pkg::*;

  logic                 tally_valid, tally_ready, go;
  vote_tally_t          tally;

  logic [SYNC_W-1:0]    sync_word_r, sync_word_nxt;
  logic [SYNC_W-1:0]    shift_r, shift_nxt;
  logic [BPOS_W-1:0]    bp_r, bp_nxt, bp_inc, bp_sync;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt, frame_upd;
  logic [1:0]           fc_r, fc_nxt, fc_upd;
  logic                 out_v_r, out_v_nxt;
  tps_out_t             out_r, res;

  logic                 bit_val, unc, match, done, cfg_wr;
  logic [VOTE_W+1:0]    z3, o3, tv;

  tpsrx_vote u_vote (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .tally_valid (tally_valid),
    .tally_ready (tally_ready),
    .tally       (tally)
  );

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_SYNC_WORD);
  assign sync_word_nxt = cfg_wr ? pwdata[SYNC_W-1:0] : sync_word_r;

  always_comb begin
    prdata = '0;
    if (paddr[CFG_AW-1:2] == REG_SYNC_WORD) begin
      prdata = CFG_DW'(sync_word_r);
    end
  end

  assign tally_ready = !out_v_r || !out_stall;
  assign go          = tally_valid && tally_ready;

  // majority and uncertainty: count > floor(total/3) is 3*count > total
  always_comb begin
    bit_val = (tally.one_votes > tally.zero_votes);
    tv      = {2'b00, tally.zero_votes} + {2'b00, tally.one_votes};
    z3      = {1'b0, tally.zero_votes, 1'b0} + {2'b00, tally.zero_votes};
    o3      = {1'b0, tally.one_votes, 1'b0} + {2'b00, tally.one_votes};
    unc     = (z3 > tv) && (o3 > tv);
  end

  always_comb begin
    shift_nxt = {shift_r[SYNC_W-2:0], bit_val};
    match     = (shift_nxt == sync_word_r) || (shift_nxt == ~sync_word_r);
    bp_inc    = bp_r + 1'b1;
    bp_sync   = match ? BPOS_W'(SYNC_END_INDEX) : bp_inc;
    done      = (bp_sync >= BPOS_W'(FRAME_BITS));

    frame_upd = frame_r;
    if (bp_r < BPOS_W'(FRAME_BITS)) begin
      frame_upd[bp_r[FIDX_W-1:0]] = bit_val;
    end

    fc_upd = (bp_sync == BPOS_W'(1)) ? fc_r + 1'b1 : fc_r;
    if (done) begin
      // frame number field holds the count of the next frame
      fc_upd = {frame_upd[FLD_FRAME_NUM], frame_upd[FLD_FRAME_NUM+1]} - 2'd1;
    end

    res                = '0;
    res.tps_bit_value  = bit_val;
    res.symbol_index   = SYM_W'(bp_sync - 1'b1);
    res.frame_number   = fc_upd;
    res.uncertain      = unc;
    res.resynced       = match && (bp_inc != BPOS_W'(SYNC_END_INDEX));
    res.frame_done     = done;
    if (done) begin
      res.constellation  = {frame_upd[FLD_CONST], frame_upd[FLD_CONST+1]};
      res.hierarchy      = {frame_upd[FLD_HIER], frame_upd[FLD_HIER+1],
                            frame_upd[FLD_HIER+2]};
      res.code_rate_hp   = {frame_upd[FLD_CR_HP], frame_upd[FLD_CR_HP+1],
                            frame_upd[FLD_CR_HP+2]};
      res.code_rate_lp   = {frame_upd[FLD_CR_LP], frame_upd[FLD_CR_LP+1],
                            frame_upd[FLD_CR_LP+2]};
      res.guard_interval = {frame_upd[FLD_GUARD], frame_upd[FLD_GUARD+1]};
      res.fft_mode       = {frame_upd[FLD_MODE], frame_upd[FLD_MODE+1]};
    end
  end

  always_comb begin
    bp_nxt    = go ? (done ? '0 : bp_sync) : bp_r;
    frame_nxt = go ? frame_upd : frame_r;
    fc_nxt    = go ? fc_upd : fc_r;
    out_v_nxt = go ? 1'b1 : (out_stall ? out_v_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= SYNC_WORD_RST;
      shift_r     <= '0;
      bp_r        <= '0;
      frame_r     <= '0;
      fc_r        <= '0;
      out_v_r     <= 1'b0;
    end else begin
      sync_word_r <= sync_word_nxt;
      shift_r     <= go ? shift_nxt : shift_r;
      bp_r        <= bp_nxt;
      frame_r     <= frame_nxt;
      fc_r        <= fc_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tpsrx_vote.sv =====
// ----------------------------------------------------------------------------
// tpsrx_vote
// Carrier store with read-modify-write, differential dot product and per-symbol
// vote counting. Emits one vote tally per symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsrx_vote (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  tpsrx_pkg::tps_in_t        in_data,
  output logic                      tally_valid,
  input  wire                       tally_ready,
  output tpsrx_pkg::vote_tally_t    tally
);
  import tpsrx_pkg::*;

  // carrier store, previous symbol's sample per carrier
  logic [2*SMP_W-1:0]   mem [MAX_CARRIERS];
  logic [MAX_CARRIERS-1:0] seen_r, seen_nxt;

  logic [CPOS_W-1:0]    cpos_r, cpos_nxt;
  logic [CADDR_W-1:0]   addr;
  logic                 acc, in_range, wr;

  // stage 1: stored sample, new sample
  logic                 s1_v_r, s1_v_nxt;
  logic signed [SMP_W-1:0] s1_re_r, s1_im_r;
  logic                 s1_rng_r, s1_last_r, s1_seen_r;
  logic [2*SMP_W-1:0]   rd_r;
  logic signed [SMP_W-1:0] prev_re, prev_im;
  logic signed [2*SMP_W-1:0] prod_re, prod_im;

  // stage 2: registered products
  logic                 s2_v_r, s2_v_nxt;
  logic signed [2*SMP_W-1:0] s2_pre_r, s2_pim_r;
  logic                 s2_rng_r, s2_last_r;
  logic signed [2*SMP_W:0] dot;
  logic                 neg;

  logic [VOTE_W-1:0]    zv_r, zv_nxt, ov_r, ov_nxt, zv_upd, ov_upd;

  // stage 3: finished tally
  logic                 t_v_r, t_v_nxt;
  vote_tally_t          t_r;

  logic                 t_rdy, s2_go, s2_rdy, s1_go, s1_rdy;

  // backpressure chain, a bubble in any stage is filled
  always_comb begin
    t_rdy    = !t_v_r || tally_ready;
    s2_go    = s2_v_r && (!s2_last_r || t_rdy);
    s2_rdy   = !s2_v_r || s2_go;
    s1_go    = s1_v_r && s2_rdy;
    s1_rdy   = !s1_v_r || s2_rdy;
    in_stall = !s1_rdy;
    acc      = in_valid && s1_rdy;
  end

  assign in_range = (cpos_r < CPOS_W'(MAX_CARRIERS));
  assign addr     = cpos_r[CADDR_W-1:0];
  assign wr       = acc && in_range;

  always_comb begin
    cpos_nxt = cpos_r;
    if (acc) begin
      if (in_data.last_carrier) begin
        cpos_nxt = '0;
      end else if (in_range) begin
        cpos_nxt = cpos_r + 1'b1;
      end
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (wr) begin
      seen_nxt[addr] = 1'b1;
    end
  end

  // read-first: the old sample comes out while the new one goes in
  always_ff @(posedge clk) begin
    if (wr) begin
      rd_r      <= mem[addr];
      mem[addr] <= {in_data.sample_re, in_data.sample_im};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      s1_seen_r <= seen_r[addr];
    end
    if (acc) begin
      s1_re_r   <= in_data.sample_re;
      s1_im_r   <= in_data.sample_im;
      s1_rng_r  <= in_range;
      s1_last_r <= in_data.last_carrier;
    end
  end

  // an entry never written reads as zero
  always_comb begin
    prev_re = s1_seen_r ? $signed(rd_r[2*SMP_W-1:SMP_W]) : '0;
    prev_im = s1_seen_r ? $signed(rd_r[SMP_W-1:0]) : '0;
    prod_re = s1_re_r * prev_re;
    prod_im = s1_im_r * prev_im;
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_pre_r  <= prod_re;
      s2_pim_r  <= prod_im;
      s2_rng_r  <= s1_rng_r;
      s2_last_r <= s1_last_r;
    end
  end

  always_comb begin
    dot    = {s2_pre_r[2*SMP_W-1], s2_pre_r} + {s2_pim_r[2*SMP_W-1], s2_pim_r};
    neg    = dot[2*SMP_W];
    zv_upd = (s2_rng_r && !neg && (zv_r != VOTE_MAX)) ? zv_r + 1'b1 : zv_r;
    ov_upd = (s2_rng_r && neg && (ov_r != VOTE_MAX)) ? ov_r + 1'b1 : ov_r;
    zv_nxt = zv_r;
    ov_nxt = ov_r;
    if (s2_go) begin
      zv_nxt = s2_last_r ? '0 : zv_upd;
      ov_nxt = s2_last_r ? '0 : ov_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_last_r) begin
      t_r.zero_votes <= zv_upd;
      t_r.one_votes  <= ov_upd;
    end
  end

  always_comb begin
    s1_v_nxt = acc ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    s2_v_nxt = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_r);
    t_v_nxt  = (s2_go && s2_last_r) ? 1'b1 : (tally_ready ? 1'b0 : t_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpos_r <= '0;
      seen_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      t_v_r  <= 1'b0;
      zv_r   <= '0;
      ov_r   <= '0;
    end else begin
      cpos_r <= cpos_nxt;
      seen_r <= seen_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      t_v_r  <= t_v_nxt;
      zv_r   <= zv_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign tally_valid = t_v_r;
  assign tally       = t_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tpsrx_checker.sv =====
// ----------------------------------------------------------------------------
// tpsrx_checker
// Port-level checks of the TPS receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tpsrx_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_stall,
  input tpsrx_pkg::tps_out_t  out_data
);
  import tpsrx_pkg::*;

  // a result waiting downstream is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // decoded fields only with a complete frame
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_done |->
      out_data.constellation == '0 && out_data.hierarchy == '0 &&
      out_data.code_rate_hp == '0 && out_data.code_rate_lp == '0 &&
      out_data.guard_interval == '0 && out_data.fft_mode == '0)
    else $error("frame fields without frame end");

  a_resync_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.resynced |->
      out_data.symbol_index == SYM_W'(SYNC_END_INDEX - 1))
    else $error("resync at wrong bit index");

  a_done_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |->
      {1'b0, out_data.symbol_index} >= (SYM_W+1)'(FRAME_BITS - 1))
    else $error("frame end before last bit");

endmodule

bind ofdm_tps_dbpsk_receiver tpsrx_checker u_tpsrx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
